@@ hw/rtl/lswkr_pkg.sv @@
// Shared constants, codes and control types for the keyed LIFO store.
`default_nettype none

package lswkr_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int KEY_W   = 16;
	localparam int CAP_W   = 5;
	localparam int STAT_W  = 2;
	localparam int MOVED_W = 5;
	localparam int OCC_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_DEPART = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_APPLY,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic find;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic depart;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/lifo_store_with_keyed_removal.sv @@
// Keyed LIFO store top level: controller and datapath.
//
// Input channel (in_valid/in_ready, func, plate) carries one operation per
// beat: func arrive pushes plate at the head, func depart finds the matching
// key nearest the head and removes it. Output channel (out_valid/out_ready,
// status, moved_count, occupancy) returns exactly one result beat per input
// beat, in order.
// Each item passes through these steps after its input beat is taken:
// key search (one parallel compare and priority pick over the filled slots), slot
// update, result shown. in_ready is high only while no item is in flight,
// so a new item is taken only after the previous result beat completes;
// the sequencer handles one item at a time.
// If the receiver stalls, the result holds on the output ports and no new
// input beat is taken until the result beat completes.
// Reset empties the store, sets capacity to 16 and clears out_valid.
// capacity is written through cfg_wr_en/cfg_wr_data; the user must write it only while idle (not enforced here).
`default_nettype none

module lifo_store_with_keyed_removal
	import lswkr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CAP_W-1:0]   cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [KEY_W-1:0]   plate,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [MOVED_W-1:0]      moved_count,
	output logic [OCC_W-1:0]        occupancy
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	lswkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lswkr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.func        (func),
		.plate       (plate),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.moved_count (moved_count),
		.occupancy   (occupancy)
	);

endmodule

`default_nettype wire

@@ hw/rtl/lswkr_ctrl.sv @@
// Sequencing state machine: load, search, update and result handoff.
`default_nettype none

module lswkr_ctrl
	import lswkr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FIND;
				end
			end
			S_FIND: begin
				cmd.find = sts.depart;
				state_d  = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/lswkr_dp.sv @@
// Datapath: slot array, fill count, key search and result registers.
`default_nettype none

module lswkr_dp
	import lswkr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CAP_W-1:0]   cfg_wr_data,
	input  wire logic               func,
	input  wire logic [KEY_W-1:0]   plate,
	input  wire dp_cmd_t            cmd,
	output dp_sts_t                 sts,
	output logic [STAT_W-1:0]       status,
	output logic [MOVED_W-1:0]      moved_count,
	output logic [OCC_W-1:0]        occupancy
);

	logic [KEY_W-1:0]   slots_q [DEPTH];
	logic [CNT_W-1:0]   fill_q;
	logic [CAP_W-1:0]   cap_q;
	logic               func_q;
	logic [KEY_W-1:0]   key_q;
	logic               hit_q;
	logic [IDX_W-1:0]   pos_q;
	logic [STAT_W-1:0]  status_q;
	logic [MOVED_W-1:0] moved_q;
	logic [OCC_W-1:0]   occ_q;

	logic               hit_d;
	logic [IDX_W-1:0]   pos_d;
	logic               full;
	logic               empty;

	assign sts.depart = (func_q == FUNC_DEPART);

	always_comb begin
		hit_d = 1'b0;
		pos_d = '0;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if ((slots_q[k] == key_q) && (CNT_W'(k) < fill_q)) begin
				hit_d = 1'b1;
				pos_d = IDX_W'(k);
			end
		end
	end

	assign full  = (32'(fill_q) >= 32'(cap_q)) || (fill_q >= CNT_W'(DEPTH));
	assign empty = (fill_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			fill_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.apply) begin
				if (!sts.depart) begin
					if (!full) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end else if (!empty && hit_q) begin
					fill_q <= fill_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= plate;
			hit_q  <= 1'b0;
			pos_q  <= '0;
		end
		if (cmd.find) begin
			hit_q <= hit_d;
			pos_q <= pos_d;
		end
		if (cmd.apply) begin
			if (!sts.depart) begin
				moved_q <= '0;
				if (full) begin
					status_q <= ST_FULL;
					occ_q    <= OCC_W'(fill_q);
				end else begin
					status_q <= ST_OK;
					occ_q    <= OCC_W'(fill_q + CNT_W'(1));
					slots_q[0] <= key_q;
					for (int k = 1; k < DEPTH; k++) begin
						slots_q[k] <= slots_q[k-1];
					end
				end
			end else if (empty) begin
				status_q <= ST_EMPTY;
				moved_q  <= '0;
				occ_q    <= OCC_W'(fill_q);
			end else if (!hit_q) begin
				status_q <= ST_MISSING;
				moved_q  <= '0;
				occ_q    <= OCC_W'(fill_q);
			end else begin
				status_q <= ST_OK;
				moved_q  <= MOVED_W'(pos_q);
				occ_q    <= OCC_W'(fill_q - CNT_W'(1));
				for (int k = 0; k < DEPTH - 1; k++) begin
					if (IDX_W'(k) >= pos_q) begin
						slots_q[k] <= slots_q[k+1];
					end
				end
			end
		end
	end

	assign status      = status_q;
	assign moved_count = moved_q;
	assign occupancy   = occ_q;

endmodule

`default_nettype wire

@@ hw/rtl/lswkr_checker.sv @@
// Port-level checker for the keyed LIFO store, with its bind.
`default_nettype none

module lswkr_props
	import lswkr_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [STAT_W-1:0]  status,
	input wire logic [MOVED_W-1:0] moved_count,
	input wire logic [OCC_W-1:0]   occupancy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(moved_count) && $stable(occupancy))
		else $error("result changed while stalled");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (occupancy == '0))
		else $error("empty status with nonzero occupancy");

	a_moved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (moved_count == '0))
		else $error("moved_count set on failed operation");

	a_moved_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (moved_count <= occupancy))
		else $error("moved_count beyond occupancy");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

endmodule

bind lifo_store_with_keyed_removal lswkr_props u_lswkr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.moved_count (moved_count),
	.occupancy   (occupancy)
);

`default_nettype wire

@@ tb/sv/lswkr_checker.sv @@
// Checker for the keyed LIFO store: tracks store contents and compares every result beat.
`timescale 1ns / 1ps

module lswkr_checker
	import lswkr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CAP_W-1:0]   cfg_wr_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               func,
	input  wire logic [KEY_W-1:0]   plate,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [STAT_W-1:0]  status,
	input  wire logic [MOVED_W-1:0] moved_count,
	input  wire logic [OCC_W-1:0]   occupancy,
	output int                      error_count,
	output int                      pending
);

	typedef struct packed {
		status_t             st;
		logic [MOVED_W-1:0]  moved;
		logic [OCC_W-1:0]    occ;
	} store_result_t;

	logic [KEY_W-1:0] stored_keys [DEPTH];
	int               stored_fill;
	logic [CAP_W-1:0] capacity_reg;
	store_result_t    expected_results [$];

	task automatic report_mismatch(string msg);
		$display("%0t: mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic store_result_t apply_operation(logic op, logic [KEY_W-1:0] key);
		store_result_t res;
		int            lim;
		int            pos;
		bit            hit;
		res.st    = ST_OK;
		res.moved = '0;
		lim       = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
		if (op == FUNC_ARRIVE) begin
			if (stored_fill >= lim) begin
				res.st = ST_FULL;
			end else begin
				for (int k = stored_fill; k > 0; k--)
					stored_keys[k] = stored_keys[k-1];
				stored_keys[0] = key;
				stored_fill++;
			end
		end else if (stored_fill == 0) begin
			res.st = ST_EMPTY;
		end else begin
			hit = 1'b0;
			pos = 0;
			for (int k = 0; k < stored_fill; k++) begin
				if (!hit && stored_keys[k] == key) begin
					hit = 1'b1;
					pos = k;
				end
			end
			if (!hit) begin
				res.st = ST_MISSING;
			end else begin
				res.moved = MOVED_W'(pos);
				for (int k = pos; k < stored_fill - 1; k++)
					stored_keys[k] = stored_keys[k+1];
				stored_fill--;
			end
		end
		res.occ = OCC_W'(stored_fill);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		store_result_t want;
		if (!arst_n) begin
			stored_fill  = 0;
			capacity_reg = CAP_RESET;
			expected_results.delete();
		end else begin
			if (cfg_wr_en)
				capacity_reg = cfg_wr_data;
			if (in_valid && in_ready)
				expected_results.push_back(apply_operation(func, plate));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing expected (status %0d)",
						status));
				end else begin
					want = expected_results.pop_front();
					if (status !== STAT_W'(want.st))
						report_mismatch($sformatf("status %s, expected %s",
							status_t'(status) == ST_OK      ? "ST_OK" :
							status_t'(status) == ST_FULL    ? "ST_FULL" :
							status_t'(status) == ST_EMPTY   ? "ST_EMPTY" : "ST_MISSING",
							want.st == ST_OK      ? "ST_OK" :
							want.st == ST_FULL    ? "ST_FULL" :
							want.st == ST_EMPTY   ? "ST_EMPTY" : "ST_MISSING"));
					if (moved_count !== want.moved)
						report_mismatch($sformatf("moved_count %0d, expected %0d",
							moved_count, want.moved));
					if (occupancy !== want.occ)
						report_mismatch($sformatf("occupancy %0d, expected %0d",
							occupancy, want.occ));
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

@@ tb/sv/tb_lifo_store_with_keyed_removal.sv @@
// Top of the keyed LIFO store testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_lifo_store_with_keyed_removal;
	import lswkr_pkg::*;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0]   cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               func        = FUNC_ARRIVE;
	logic [KEY_W-1:0]   plate       = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [MOVED_W-1:0] moved_count;
	logic [OCC_W-1:0]   occupancy;
	int                 error_count;
	int                 pending;

	bit                 tx_gaps_on  = 1'b0;
	bit                 rx_stall_on = 1'b0;
	int                 rx_hold_left = 0;
	logic [KEY_W-1:0]   recent_keys [$];

	lifo_store_with_keyed_removal u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.plate       (plate),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.moved_count (moved_count),
		.occupancy   (occupancy)
	);

	lswkr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.plate       (plate),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.moved_count (moved_count),
		.occupancy   (occupancy),
		.error_count (error_count),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			out_ready    <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
			out_ready    <= 1'b0;
			rx_hold_left <= gap_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_op(logic op, logic [KEY_W-1:0] key);
		in_valid <= 1'b1;
		func     <= op;
		plate    <= key;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		if (op == FUNC_ARRIVE) begin
			recent_keys.push_back(key);
			if (recent_keys.size() > 24)
				void'(recent_keys.pop_front());
		end
	endtask

	task automatic tx_gap();
		int n;
		n = tx_gaps_on ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] arrive_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return '1;
		else if (r < 55)
			return KEY_W'($urandom_range(0, 15));
		else
			return KEY_W'($urandom());
	endfunction

	function automatic logic [KEY_W-1:0] depart_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70 && recent_keys.size() != 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		else if (r < 80)
			return KEY_W'($urandom_range(0, 15));
		else
			return KEY_W'($urandom());
	endfunction

	initial begin
		logic [CAP_W-1:0] cap_plan [10];
		int               arrive_pct;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(FUNC_DEPART, 16'h1234);
		send_op(FUNC_ARRIVE, 16'h0000);
		send_op(FUNC_ARRIVE, 16'hFFFF);
		send_op(FUNC_ARRIVE, 16'hAAAA);
		send_op(FUNC_ARRIVE, 16'h5555);
		send_op(FUNC_ARRIVE, 16'hAAAA);
		send_op(FUNC_DEPART, 16'hAAAA);
		send_op(FUNC_DEPART, 16'h0000);
		send_op(FUNC_DEPART, 16'h7777);
		for (int k = 1; k <= 13; k++)
			send_op(FUNC_ARRIVE, KEY_W'(k * 16'h1111));
		send_op(FUNC_ARRIVE, 16'hBEEF);
		send_op(FUNC_DEPART, 16'hFFFF);

		write_capacity(CAP_W'(2));
		send_op(FUNC_ARRIVE, 16'h0F0F);
		send_op(FUNC_DEPART, 16'h1111);
		write_capacity(CAP_W'(0));
		send_op(FUNC_ARRIVE, 16'hF0F0);
		write_capacity(CAP_W'(31));
		send_op(FUNC_ARRIVE, 16'h0001);
		send_op(FUNC_ARRIVE, 16'h8000);
		send_op(FUNC_ARRIVE, 16'h8001);

		cap_plan = '{CAP_W'(1), CAP_W'(16), CAP_W'(31), CAP_W'(0), CAP_W'(5),
			CAP_W'(17), CAP_W'(2), CAP_W'(15), CAP_W'(8), CAP_W'(16)};
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 8)
				write_capacity(CAP_W'($urandom_range(0, 31)));
			else
				write_capacity(cap_plan[ph]);
			for (int chunk = 0; chunk < 5; chunk++) begin
				tx_gaps_on  = $urandom_range(0, 2) != 0;
				rx_stall_on = $urandom_range(0, 2) != 0;
				arrive_pct  = (chunk % 2 == 0) ? 70 : 30;
				for (int i = 0; i < 27; i++) begin
					tx_gap();
					if ($urandom_range(0, 99) < arrive_pct)
						send_op(FUNC_ARRIVE, arrive_key());
					else
						send_op(FUNC_DEPART, depart_key());
				end
				if (chunk == 2)
					drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/lswkr_pkg.sv
hw/rtl/lswkr_ctrl.sv
hw/rtl/lswkr_dp.sv
hw/rtl/lifo_store_with_keyed_removal.sv
hw/rtl/lswkr_checker.sv
tb/sv/lswkr_checker.sv
tb/sv/tb_lifo_store_with_keyed_removal.sv
